>>> src/afc_pkg.sv
package afc_pkg;

    // Number of plane registers and the cap on the active plane count.
    localparam int NUM_PLANES = 6;

    // Field widths.
    localparam int BOX_W    = 24;
    localparam int NORM_W   = 12;
    localparam int DIST_W   = 28;
    localparam int DIST_SH  = 10;
    localparam int COORD_W  = BOX_W + 2;
    localparam int PROD_W   = NORM_W + COORD_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int COUNT_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_C     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_E     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_F     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd6;

    // Verdict codes.
    localparam logic [1:0] VERDICT_INSIDE     = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECTS = 2'd1;
    localparam logic [1:0] VERDICT_OUTSIDE    = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [CFG_DAT_W-1:0]      plane_word_t;

    // Load enables of the pipeline stages kept inside the plane units.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

>>> src/afc_plane_eval.sv
// Tests one box against one plane over four stages: products, per-axis
// minimum and maximum, sums, and the compare against the plane distance.
// Since the dot product splits by axis, the smallest and largest corner
// values are sums of per-axis extremes, so all eight corners are covered.
module afc_plane_eval
(
    input  logic                   clk,
    input  afc_pkg::stage_en_t     en,
    input  afc_pkg::plane_word_t   plane,
    input  afc_pkg::coord_t        lo [3],
    input  afc_pkg::coord_t        hi [3],
    output logic                   all_over,
    output logic                   none_over
);

    logic signed [afc_pkg::NORM_W-1:0] normal [3];
    logic signed [afc_pkg::DIST_W-1:0] plane_dist;
    afc_pkg::sum_t                     dist_scaled;

    afc_pkg::prod_t prod_lo_reg [3];
    afc_pkg::prod_t prod_hi_reg [3];
    afc_pkg::prod_t ax_min_reg  [3];
    afc_pkg::prod_t ax_max_reg  [3];
    afc_pkg::sum_t  sum_min_reg;
    afc_pkg::sum_t  sum_max_reg;
    logic           all_over_reg;
    logic           none_over_reg;

    // Unpack the plane word.
    assign normal[0]  = plane[11:0];
    assign normal[1]  = plane[23:12];
    assign normal[2]  = plane[35:24];
    assign plane_dist = plane[63:36];
    assign dist_scaled = {{(afc_pkg::SUM_W - afc_pkg::DIST_W - afc_pkg::DIST_SH){plane_dist[
        afc_pkg::DIST_W-1]}}, plane_dist, {afc_pkg::DIST_SH{1'b0}}};

    // Stage 2: normal times both ends of each axis.
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_lo_reg[k] <= afc_pkg::PROD_W'(normal[k] * lo[k]);
                prod_hi_reg[k] <= afc_pkg::PROD_W'(normal[k] * hi[k]);
            end
        end
    end

    // Stage 3: per-axis minimum and maximum product.
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (prod_lo_reg[k] <= prod_hi_reg[k])
                begin
                    ax_min_reg[k] <= prod_lo_reg[k];
                    ax_max_reg[k] <= prod_hi_reg[k];
                end
                else
                begin
                    ax_min_reg[k] <= prod_hi_reg[k];
                    ax_max_reg[k] <= prod_lo_reg[k];
                end
            end
        end
    end

    // Stage 4: smallest and largest corner dot products.
    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            sum_min_reg <= afc_pkg::SUM_W'(ax_min_reg[0]) + afc_pkg::SUM_W'(ax_min_reg[1])
                         + afc_pkg::SUM_W'(ax_min_reg[2]);
            sum_max_reg <= afc_pkg::SUM_W'(ax_max_reg[0]) + afc_pkg::SUM_W'(ax_max_reg[1])
                         + afc_pkg::SUM_W'(ax_max_reg[2]);
        end
    end

    // Stage 5: every corner over the plane, or none of them.
    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            all_over_reg  <= (sum_min_reg > dist_scaled);
            none_over_reg <= !(sum_max_reg > dist_scaled);
        end
    end

    assign all_over  = all_over_reg;
    assign none_over = none_over_reg;

endmodule

>>> src/aabb_frustum_classifier_top.sv
// Channel  Direction  Signals                                        Transaction
// in       input      in_valid, in_ready, box_*, extent_*            one box
// out      output     out_valid, out_ready, verdict                  one verdict
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data      one register write
//
// One box is taken per cycle while no stall on the output holds the pipeline full.
// Each box passes through six register stages: corner ends, products,
// per-axis extremes, sums, plane compares, and the output register.
// Each stage has its own valid bit and holds only while it is full and the stage
// after it holds, so a stall on the output fills empty stages first and drops nothing.
// Reset clears all valid bits, the plane registers and the plane count.
module aabb_frustum_classifier_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [afc_pkg::BOX_W-1:0]      box_x,
    input  logic signed [afc_pkg::BOX_W-1:0]      box_y,
    input  logic signed [afc_pkg::BOX_W-1:0]      box_z,
    input  logic        [afc_pkg::BOX_W-1:0]      extent_x,
    input  logic        [afc_pkg::BOX_W-1:0]      extent_y,
    input  logic        [afc_pkg::BOX_W-1:0]      extent_z,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic        [1:0]                     verdict,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [afc_pkg::CFG_DAT_W-1:0]  cfg_data
);

    afc_pkg::plane_word_t              plane_reg [afc_pkg::NUM_PLANES];
    logic [afc_pkg::COUNT_W-1:0]       plane_count_reg;
    logic [afc_pkg::COUNT_W-1:0]       active_count;

    afc_pkg::coord_t                   lo_reg [3];
    afc_pkg::coord_t                   hi_reg [3];
    logic                              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                              en1, en_out;
    afc_pkg::stage_en_t                en;

    logic [afc_pkg::NUM_PLANES-1:0]    all_over;
    logic [afc_pkg::NUM_PLANES-1:0]    none_over;
    logic                              any_outside;
    logic                              all_inside;
    logic [1:0]                        verdict_next;
    logic [1:0]                        verdict_reg;
    logic                              out_valid_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
            begin
                plane_reg[p] <= '0;
            end
            plane_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                afc_pkg::REG_PLANE_A:     plane_reg[0] <= cfg_data;
                afc_pkg::REG_PLANE_B:     plane_reg[1] <= cfg_data;
                afc_pkg::REG_PLANE_C:     plane_reg[2] <= cfg_data;
                afc_pkg::REG_PLANE_D:     plane_reg[3] <= cfg_data;
                afc_pkg::REG_PLANE_E:     plane_reg[4] <= cfg_data;
                afc_pkg::REG_PLANE_F:     plane_reg[5] <= cfg_data;
                afc_pkg::REG_PLANE_COUNT: plane_count_reg <= cfg_data[afc_pkg::COUNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // A count above the number of planes saturates.
    assign active_count = (plane_count_reg > afc_pkg::COUNT_W'(afc_pkg::NUM_PLANES))
                        ? afc_pkg::COUNT_W'(afc_pkg::NUM_PLANES) : plane_count_reg;

    // Stage enables: a stage loads when it is empty or its successor loads.
    assign en_out = !out_valid_reg || out_ready;
    assign en.s5  = !v5_reg || en_out;
    assign en.s4  = !v4_reg || en.s5;
    assign en.s3  = !v3_reg || en.s4;
    assign en.s2  = !v2_reg || en.s3;
    assign en1    = !v1_reg || en.s2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (en.s5)
            begin
                v5_reg <= v4_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v5_reg;
            end
        end
    end

    // Stage 1: low and high end of each axis.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            lo_reg[0] <= afc_pkg::COORD_W'(box_x);
            lo_reg[1] <= afc_pkg::COORD_W'(box_y);
            lo_reg[2] <= afc_pkg::COORD_W'(box_z);
            hi_reg[0] <= afc_pkg::COORD_W'(box_x) + afc_pkg::coord_t'({2'b00, extent_x});
            hi_reg[1] <= afc_pkg::COORD_W'(box_y) + afc_pkg::coord_t'({2'b00, extent_y});
            hi_reg[2] <= afc_pkg::COORD_W'(box_z) + afc_pkg::coord_t'({2'b00, extent_z});
        end
    end

    // One plane unit per plane register.
    for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++)
    begin : g_plane
        afc_plane_eval u_plane
        (
            .clk       (clk),
            .en        (en),
            .plane     (plane_reg[p]),
            .lo        (lo_reg),
            .hi        (hi_reg),
            .all_over  (all_over[p]),
            .none_over (none_over[p])
        );
    end

    // Combine the active planes into a verdict.
    always_comb
    begin
        any_outside = 1'b0;
        all_inside  = 1'b1;
        for (int p = 0; p < afc_pkg::NUM_PLANES; p++)
        begin
            if (afc_pkg::COUNT_W'(p) < active_count)
            begin
                any_outside = any_outside || all_over[p];
                all_inside  = all_inside && none_over[p];
            end
        end
        priority if (any_outside)
        begin
            verdict_next = afc_pkg::VERDICT_OUTSIDE;
        end
        else if (all_inside)
        begin
            verdict_next = afc_pkg::VERDICT_INSIDE;
        end
        else
        begin
            verdict_next = afc_pkg::VERDICT_INTERSECTS;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule
